@@ sv/q2e_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// q2e_pkg
// Shared widths, constants, the CORDIC arctangent table and the queue status
// type for the quaternion to Euler angle converter.
// ----------------------------------------------------------------------------
package q2e_pkg;

   localparam int COMP_W     = 16;   // quaternion component width
   localparam int PROD_W     = 32;   // 16 x 16 signed product
   localparam int SIN_W      = 32;   // asin argument, Q30
   localparam int ROOT_W     = 31;   // sqrt(1 - s^2), Q30
   localparam int SQ_W       = 61;   // radicand, Q60
   localparam int SQRT_STEPS = 31;   // one result bit per step
   localparam int ANG_W      = 35;   // Q30 angle accumulator
   localparam int CORD_W     = 44;   // CORDIC x/y datapath
   localparam int NORM_MSB   = 39;   // leading one of max(|x|,|y|) after normalizing
   localparam int RND_SHIFT  = 18;   // Q30 to Q12

   localparam int YAW_W      = 15;
   localparam int ROLL_W     = 14;
   localparam int YAW_LIM    = 12868;
   localparam int ROLL_LIM   = 6434;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QCNT_W      = 3;

   localparam logic signed [ANG_W-1:0] PI_Q30 = 35'sd3373259426;

   typedef struct packed {
      logic full;
      logic empty;
   } q2e_qstat_type;

   // atan(2^-i) in Q30
   function automatic logic [31:0] atan_q30(input logic [4:0] idx);
      logic [31:0] t;
      case (idx)
         5'd0:    t = 32'h3243F6A8;
         5'd1:    t = 32'h1DAC6705;
         5'd2:    t = 32'h0FADBAFC;
         5'd3:    t = 32'h07F56EA6;
         5'd4:    t = 32'h03FEAB76;
         5'd5:    t = 32'h01FFD55B;
         5'd6:    t = 32'h00FFFAAA;
         5'd7:    t = 32'h007FFF55;
         5'd8:    t = 32'h003FFFEA;
         5'd9:    t = 32'h001FFFFD;
         5'd10:   t = 32'h000FFFFF;
         5'd11:   t = 32'h0007FFFF;
         5'd12:   t = 32'h0003FFFF;
         5'd13:   t = 32'h0001FFFF;
         5'd14:   t = 32'h0000FFFF;
         5'd15:   t = 32'h00007FFF;
         5'd16:   t = 32'h00003FFF;
         5'd17:   t = 32'h00001FFF;
         5'd18:   t = 32'h00000FFF;
         5'd19:   t = 32'h000007FF;
         5'd20:   t = 32'h000003FF;
         5'd21:   t = 32'h000001FF;
         5'd22:   t = 32'h000000FF;
         5'd23:   t = 32'h0000007F;
         5'd24:   t = 32'h0000003F;
         5'd25:   t = 32'h0000001F;
         5'd26:   t = 32'h0000000F;
         5'd27:   t = 32'h00000008;
         5'd28:   t = 32'h00000004;
         5'd29:   t = 32'h00000002;
         5'd30:   t = 32'h00000001;
         default: t = 32'h00000000;
      endcase
      return t;
   endfunction

endpackage
`default_nettype wire

@@ sv/q2e_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// q2e_front
// Front end: captures a quaternion, forms the atan2 operands and the clamped
// asin argument, and runs a pipelined integer square root for the roll cosine.
// ----------------------------------------------------------------------------
module q2e_front
   import q2e_pkg::*;
#(
   parameter int INPUT_FRAC_BITS = 14,
   parameter int TERM_W          = 35
)(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic signed [COMP_W-1:0] req_qx,
   input  wire logic signed [COMP_W-1:0] req_qy,
   input  wire logic signed [COMP_W-1:0] req_qz,
   input  wire logic signed [COMP_W-1:0] req_qw,
   input  wire q2e_qstat_type            q_stat,
   output logic                          push,
   output logic signed [TERM_W-1:0]      yaw_y,
   output logic signed [TERM_W-1:0]      yaw_x,
   output logic signed [TERM_W-1:0]      pit_y,
   output logic signed [TERM_W-1:0]      pit_x,
   output logic signed [SIN_W-1:0]       sin_q30,
   output logic [ROOT_W-1:0]             cos_q30,
   output logic                          clamped
);

   localparam int TWO_F = 2 * INPUT_FRAC_BITS;
   localparam int SH_DN = (TWO_F >= 30) ? TWO_F - 30 : 0;
   localparam int SH_UP = (TWO_F < 30) ? 30 - TWO_F : 0;
   localparam int RT_W  = SQ_W + 1;
   localparam logic signed [TERM_W-1:0] ONE = TERM_W'(1) << TWO_F;

   logic adv;

   // input capture
   logic                     vld0_ff;
   logic signed [COMP_W-1:0] qx_ff, qy_ff, qz_ff, qw_ff;

   // products
   logic                     vld1_ff;
   logic signed [PROD_W-1:0] p_xx_ff, p_yy_ff, p_zz_ff, p_xy_ff, p_xz_ff;
   logic signed [PROD_W-1:0] p_xw_ff, p_yz_ff, p_yw_ff, p_zw_ff;

   // terms
   logic                     vld2_ff;
   logic signed [TERM_W-1:0] yaw_y_in, yaw_x_in, pit_y_in, pit_x_in;
   logic signed [TERM_W-1:0] yaw_y_ff, yaw_x_ff, pit_y_ff, pit_x_ff;
   logic signed [TERM_W-1:0] s_raw, s_cl, s_wide;
   logic signed [SIN_W-1:0]  sin_in, sin_ff;
   logic                     clamp_in, clamp_ff;

   // square root stages; index 0 holds the radicand
   logic                     sq_vld_ff [SQRT_STEPS+1];
   logic [SQ_W-1:0]          v_ff      [SQRT_STEPS+1];
   logic [RT_W-1:0]          r_ff      [SQRT_STEPS+1];
   logic [SQ_W-1:0]          v_in      [SQRT_STEPS+1];
   logic [RT_W-1:0]          r_in      [SQRT_STEPS+1];
   logic [RT_W-1:0]          trial     [SQRT_STEPS+1];
   logic signed [TERM_W-1:0] d_yaw_y_ff [SQRT_STEPS+1];
   logic signed [TERM_W-1:0] d_yaw_x_ff [SQRT_STEPS+1];
   logic signed [TERM_W-1:0] d_pit_y_ff [SQRT_STEPS+1];
   logic signed [TERM_W-1:0] d_pit_x_ff [SQRT_STEPS+1];
   logic signed [SIN_W-1:0]  d_sin_ff   [SQRT_STEPS+1];
   logic                     d_clamp_ff [SQRT_STEPS+1];
   logic [ROOT_W-1:0]        sin_mag;
   logic [2*ROOT_W-1:0]      sin_sq;
   logic [SQ_W-1:0]          rad_in;

   // hold the whole front only when the last stage cannot enter the queue
   assign adv       = !(sq_vld_ff[SQRT_STEPS] && q_stat.full);
   assign req_stall = !adv;
   assign push      = adv && sq_vld_ff[SQRT_STEPS];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld0_ff <= 1'b0;
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
         for (int k = 0; k <= SQRT_STEPS; k++) begin
            sq_vld_ff[k] <= 1'b0;
         end
      end else if (adv) begin
         vld0_ff      <= req_valid;
         vld1_ff      <= vld0_ff;
         vld2_ff      <= vld1_ff;
         sq_vld_ff[0] <= vld2_ff;
         for (int k = 1; k <= SQRT_STEPS; k++) begin
            sq_vld_ff[k] <= sq_vld_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         qx_ff   <= req_qx;
         qy_ff   <= req_qy;
         qz_ff   <= req_qz;
         qw_ff   <= req_qw;
         p_xx_ff <= qx_ff * qx_ff;
         p_yy_ff <= qy_ff * qy_ff;
         p_zz_ff <= qz_ff * qz_ff;
         p_xy_ff <= qx_ff * qy_ff;
         p_xz_ff <= qx_ff * qz_ff;
         p_xw_ff <= qx_ff * qw_ff;
         p_yz_ff <= qy_ff * qz_ff;
         p_yw_ff <= qy_ff * qw_ff;
         p_zw_ff <= qz_ff * qw_ff;
         yaw_y_ff <= yaw_y_in;
         yaw_x_ff <= yaw_x_in;
         pit_y_ff <= pit_y_in;
         pit_x_ff <= pit_x_in;
         sin_ff   <= sin_in;
         clamp_ff <= clamp_in;
      end
   end

   always_comb begin
      yaw_y_in = (TERM_W'(p_yw_ff) - TERM_W'(p_xz_ff)) <<< 1;
      yaw_x_in = ONE - ((TERM_W'(p_yy_ff) + TERM_W'(p_zz_ff)) <<< 1);
      pit_y_in = (TERM_W'(p_xw_ff) - TERM_W'(p_yz_ff)) <<< 1;
      pit_x_in = ONE - ((TERM_W'(p_xx_ff) + TERM_W'(p_zz_ff)) <<< 1);
      s_raw    = (TERM_W'(p_xy_ff) + TERM_W'(p_zw_ff)) <<< 1;
      // saturate the asin argument to +-1
      if (s_raw > ONE) begin
         s_cl     = ONE;
         clamp_in = 1'b1;
      end else if (s_raw < -ONE) begin
         s_cl     = -ONE;
         clamp_in = 1'b1;
      end else begin
         s_cl     = s_raw;
         clamp_in = 1'b0;
      end
      s_wide = (s_cl >>> SH_DN) <<< SH_UP;
      sin_in = s_wide[SIN_W-1:0];
   end

   assign sin_mag = sin_ff[SIN_W-1] ? ROOT_W'(-sin_ff) : ROOT_W'(sin_ff);
   assign sin_sq  = sin_mag * sin_mag;
   assign rad_in  = (SQ_W'(1) << 60) - sin_sq[SQ_W-1:0];

   always_comb begin
      v_in[0]  = rad_in;
      r_in[0]  = '0;
      trial[0] = '0;
      for (int k = 1; k <= SQRT_STEPS; k++) begin
         trial[k] = r_ff[k-1] + (RT_W'(1) << (2 * (SQRT_STEPS - k)));
         if ({1'b0, v_ff[k-1]} >= trial[k]) begin
            v_in[k] = v_ff[k-1] - trial[k][SQ_W-1:0];
            r_in[k] = (r_ff[k-1] >> 1) + (RT_W'(1) << (2 * (SQRT_STEPS - k)));
         end else begin
            v_in[k] = v_ff[k-1];
            r_in[k] = r_ff[k-1] >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         v_ff[0]       <= v_in[0];
         r_ff[0]       <= r_in[0];
         d_yaw_y_ff[0] <= yaw_y_ff;
         d_yaw_x_ff[0] <= yaw_x_ff;
         d_pit_y_ff[0] <= pit_y_ff;
         d_pit_x_ff[0] <= pit_x_ff;
         d_sin_ff[0]   <= sin_ff;
         d_clamp_ff[0] <= clamp_ff;
         for (int k = 1; k <= SQRT_STEPS; k++) begin
            v_ff[k]       <= v_in[k];
            r_ff[k]       <= r_in[k];
            d_yaw_y_ff[k] <= d_yaw_y_ff[k-1];
            d_yaw_x_ff[k] <= d_yaw_x_ff[k-1];
            d_pit_y_ff[k] <= d_pit_y_ff[k-1];
            d_pit_x_ff[k] <= d_pit_x_ff[k-1];
            d_sin_ff[k]   <= d_sin_ff[k-1];
            d_clamp_ff[k] <= d_clamp_ff[k-1];
         end
      end
   end

   assign yaw_y   = d_yaw_y_ff[SQRT_STEPS];
   assign yaw_x   = d_yaw_x_ff[SQRT_STEPS];
   assign pit_y   = d_pit_y_ff[SQRT_STEPS];
   assign pit_x   = d_pit_x_ff[SQRT_STEPS];
   assign sin_q30 = d_sin_ff[SQRT_STEPS];
   assign cos_q30 = r_ff[SQRT_STEPS][ROOT_W-1:0];
   assign clamped = d_clamp_ff[SQRT_STEPS];

endmodule
`default_nettype wire

@@ sv/q2e_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// q2e_queue
// Short FIFO between the front end and the CORDIC back end.
// ----------------------------------------------------------------------------
module q2e_queue
   import q2e_pkg::*;
#(
   parameter int W = 8
)(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push,
   input  wire logic [W-1:0] wdata,
   input  wire logic         pop,
   output logic [W-1:0]      rdata,
   output q2e_qstat_type     stat
);

   logic [W-1:0]      mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign count_in   = count_ff + QCNT_W'(push) - QCNT_W'(pop);
   assign stat.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign stat.empty = (count_ff == '0);
   assign rdata      = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !stat.full)
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !stat.empty)
      else $error("queue read while empty");

   a_count_up: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + QCNT_W'(1)))
      else $error("queue count lost a transaction");

endmodule
`default_nettype wire

@@ sv/q2e_atan.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// q2e_atan
// Pipelined atan2: half-plane fold, leading-one search, normalizing shift,
// one CORDIC vectoring stage per step, then rounding to Q3.12 with saturation.
// ----------------------------------------------------------------------------
module q2e_atan
   import q2e_pkg::*;
#(
   parameter int IN_W         = 35,
   parameter int CORDIC_STEPS = 16,
   parameter int OUT_W        = 15,
   parameter int LIMIT        = 12868
)(
   input  wire logic                   clock,
   input  wire logic                   en,
   input  wire logic signed [IN_W-1:0] y,
   input  wire logic signed [IN_W-1:0] x,
   output logic signed [OUT_W-1:0]     angle
);

   localparam int PW = $clog2(IN_W + NORM_MSB + 2);
   localparam int XW = IN_W + 1 + NORM_MSB;
   localparam int RQ_W = ANG_W - RND_SHIFT + 1;

   // fold
   logic signed [IN_W:0]  xe, ye, xn_in, yn_in, xn_ff, yn_ff;
   logic [IN_W:0]         ax, ay, m_in, m_ff;
   logic signed [ANG_W-1:0] base_in, base_ff;
   logic                  neg;

   // leading-one search
   logic [PW-1:0]         p_in, p_ff;
   logic                  zero_ff;
   logic signed [IN_W:0]  xn2_ff, yn2_ff;
   logic signed [ANG_W-1:0] base2_ff;

   // normalize
   logic signed [XW-1:0]  xw, yw, xsh, ysh;

   // CORDIC stages; index 0 is the normalized vector
   logic signed [CORD_W-1:0] cx_ff [CORDIC_STEPS+1];
   logic signed [CORD_W-1:0] cy_ff [CORDIC_STEPS+1];
   logic signed [ANG_W-1:0]  cz_ff [CORDIC_STEPS+1];
   logic                     cz0_ff [CORDIC_STEPS+1];
   logic signed [CORD_W-1:0] cx_in [CORDIC_STEPS+1];
   logic signed [CORD_W-1:0] cy_in [CORDIC_STEPS+1];
   logic signed [ANG_W-1:0]  cz_in [CORDIC_STEPS+1];

   // round
   logic signed [ANG_W:0]           rsum;
   logic signed [ANG_W-RND_SHIFT:0] rq;
   logic signed [OUT_W-1:0]         angle_in, angle_ff;

   always_comb begin
      xe    = {x[IN_W-1], x};
      ye    = {y[IN_W-1], y};
      neg   = x[IN_W-1];
      // negative x: rotate by pi first
      xn_in = neg ? -xe : xe;
      yn_in = neg ? -ye : ye;
      ax    = xn_in;
      ay    = yn_in[IN_W] ? -yn_in : yn_in;
      m_in  = (ax > ay) ? ax : ay;
      if (neg) begin
         base_in = y[IN_W-1] ? -PI_Q30 : PI_Q30;
      end else begin
         base_in = '0;
      end
   end

   always_comb begin
      p_in = '0;
      for (int i = 0; i <= IN_W; i++) begin
         if (m_ff[i]) begin
            p_in = PW'(i);
         end
      end
   end

   always_comb begin
      xw = XW'(xn2_ff);
      yw = XW'(yn2_ff);
      if (p_ff >= PW'(NORM_MSB)) begin
         xsh = xw >>> (p_ff - PW'(NORM_MSB));
         ysh = yw >>> (p_ff - PW'(NORM_MSB));
      end else begin
         xsh = xw <<< (PW'(NORM_MSB) - p_ff);
         ysh = yw <<< (PW'(NORM_MSB) - p_ff);
      end
      cx_in[0] = xsh[CORD_W-1:0];
      cy_in[0] = ysh[CORD_W-1:0];
      cz_in[0] = base2_ff;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         if (!cy_ff[i][CORD_W-1]) begin
            cx_in[i+1] = cx_ff[i] + (cy_ff[i] >>> i);
            cy_in[i+1] = cy_ff[i] - (cx_ff[i] >>> i);
            cz_in[i+1] = cz_ff[i] + ANG_W'(atan_q30(5'(i)));
         end else begin
            cx_in[i+1] = cx_ff[i] - (cy_ff[i] >>> i);
            cy_in[i+1] = cy_ff[i] + (cx_ff[i] >>> i);
            cz_in[i+1] = cz_ff[i] - ANG_W'(atan_q30(5'(i)));
         end
      end
   end

   always_comb begin
      rsum = (ANG_W + 1)'(cz_ff[CORDIC_STEPS]) + (ANG_W + 1)'(1 << (RND_SHIFT - 1));
      rq   = RQ_W'(rsum >>> RND_SHIFT);
      if (cz0_ff[CORDIC_STEPS]) begin
         angle_in = '0;
      end else if (rq > RQ_W'(LIMIT)) begin
         angle_in = OUT_W'(LIMIT);
      end else if (rq < -(RQ_W'(LIMIT))) begin
         angle_in = -OUT_W'(LIMIT);
      end else begin
         angle_in = rq[OUT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         xn_ff     <= xn_in;
         yn_ff     <= yn_in;
         m_ff      <= m_in;
         base_ff   <= base_in;
         p_ff      <= p_in;
         zero_ff   <= (m_ff == '0);
         xn2_ff    <= xn_ff;
         yn2_ff    <= yn_ff;
         base2_ff  <= base_ff;
         cz0_ff[0] <= zero_ff;
         for (int i = 0; i <= CORDIC_STEPS; i++) begin
            cx_ff[i] <= cx_in[i];
            cy_ff[i] <= cy_in[i];
            cz_ff[i] <= cz_in[i];
         end
         for (int i = 1; i <= CORDIC_STEPS; i++) begin
            cz0_ff[i] <= cz0_ff[i-1];
         end
         angle_ff <= angle_in;
      end
   end

   assign angle = angle_ff;

endmodule
`default_nettype wire

@@ sv/q2e_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// q2e_back
// Back end: three atan2 pipelines fed from the queue head, with a valid and
// clamp-flag shadow pipeline ending in the result register.
// ----------------------------------------------------------------------------
module q2e_back
   import q2e_pkg::*;
#(
   parameter int TERM_W       = 35,
   parameter int CORDIC_STEPS = 16
)(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire q2e_qstat_type            q_stat,
   output logic                          pop,
   input  wire logic signed [TERM_W-1:0] yaw_y,
   input  wire logic signed [TERM_W-1:0] yaw_x,
   input  wire logic signed [TERM_W-1:0] pit_y,
   input  wire logic signed [TERM_W-1:0] pit_x,
   input  wire logic signed [SIN_W-1:0]  sin_q30,
   input  wire logic [ROOT_W-1:0]        cos_q30,
   input  wire logic                     clamped,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic signed [YAW_W-1:0]       rsp_yaw_angle,
   output logic signed [YAW_W-1:0]       rsp_pitch_angle,
   output logic signed [ROLL_W-1:0]      rsp_roll_angle,
   output logic                          rsp_roll_clamped
);

   localparam int LAT = CORDIC_STEPS + 4;

   logic adv;
   logic vld_ff   [LAT];
   logic clamp_ff [LAT];
   logic signed [TERM_W-1:0] sin_ext, cos_ext;

   // freeze only while a result waits on a stalled receiver
   assign adv = !(vld_ff[LAT-1] && rsp_stall);
   assign pop = adv && !q_stat.empty;

   assign sin_ext = TERM_W'(sin_q30);
   assign cos_ext = TERM_W'({1'b0, cos_q30});

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LAT; i++) begin
            vld_ff[i] <= 1'b0;
         end
      end else if (adv) begin
         vld_ff[0] <= !q_stat.empty;
         for (int i = 1; i < LAT; i++) begin
            vld_ff[i] <= vld_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         clamp_ff[0] <= clamped;
         for (int i = 1; i < LAT; i++) begin
            clamp_ff[i] <= clamp_ff[i-1];
         end
      end
   end

   q2e_atan #(
      .IN_W(TERM_W), .CORDIC_STEPS(CORDIC_STEPS), .OUT_W(YAW_W), .LIMIT(YAW_LIM)
   ) u_yaw (
      .clock(clock), .en(adv), .y(yaw_y), .x(yaw_x), .angle(rsp_yaw_angle)
   );

   q2e_atan #(
      .IN_W(TERM_W), .CORDIC_STEPS(CORDIC_STEPS), .OUT_W(YAW_W), .LIMIT(YAW_LIM)
   ) u_pitch (
      .clock(clock), .en(adv), .y(pit_y), .x(pit_x), .angle(rsp_pitch_angle)
   );

   q2e_atan #(
      .IN_W(TERM_W), .CORDIC_STEPS(CORDIC_STEPS), .OUT_W(ROLL_W), .LIMIT(ROLL_LIM)
   ) u_roll (
      .clock(clock), .en(adv), .y(sin_ext), .x(cos_ext), .angle(rsp_roll_angle)
   );

   assign rsp_valid        = vld_ff[LAT-1];
   assign rsp_roll_clamped = clamp_ff[LAT-1];

endmodule
`default_nettype wire

@@ sv/quaternion_to_euler.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// quaternion_to_euler
// Converts a Q2.14 quaternion to yaw and pitch in Q3.12 and roll in Q2.12 radians.
// ----------------------------------------------------------------------------
// Usage:
//   Present qx/qy/qz/qw with req_valid; the transaction is taken on a clock
//   edge where req_stall is low. Results leave on rsp_* with rsp_valid; the
//   receiver holds rsp_stall high to keep a result in place.
//   With no stall, a transaction passes through the front end (products, terms
//   and a 31-step square root), then the queue, then the atan2 pipelines.
//   Throughput is one transaction per cycle while req_stall is low; each
//   square-root step and each CORDIC iteration is a stage of its own.
//   When the receiver stalls, the back end holds its result register and the
//   front end keeps running until the 4-entry queue fills, then asserts
//   req_stall. Reset empties all stages and the queue; no clearing pass.
//   roll_clamped marks an asin argument saturated to +-1.
// ----------------------------------------------------------------------------
module quaternion_to_euler
   import q2e_pkg::*;
#(
   parameter int INPUT_FRAC_BITS = 14,
   parameter int CORDIC_STEPS    = 16
)(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic signed [COMP_W-1:0] req_qx,
   input  wire logic signed [COMP_W-1:0] req_qy,
   input  wire logic signed [COMP_W-1:0] req_qz,
   input  wire logic signed [COMP_W-1:0] req_qw,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic signed [YAW_W-1:0]       rsp_yaw_angle,
   output logic signed [YAW_W-1:0]       rsp_pitch_angle,
   output logic signed [ROLL_W-1:0]      rsp_roll_angle,
   output logic                          rsp_roll_clamped
);

   localparam int TERM_W = (2 * INPUT_FRAC_BITS + 2 > 35) ? 2 * INPUT_FRAC_BITS + 2 : 35;
   localparam int QW     = 4 * TERM_W + SIN_W + ROOT_W + 1;

   q2e_qstat_type            q_stat;
   logic                     push, pop;
   logic signed [TERM_W-1:0] f_yaw_y, f_yaw_x, f_pit_y, f_pit_x;
   logic signed [TERM_W-1:0] b_yaw_y, b_yaw_x, b_pit_y, b_pit_x;
   logic signed [SIN_W-1:0]  f_sin, b_sin;
   logic [ROOT_W-1:0]        f_cos, b_cos;
   logic                     f_clamp, b_clamp;
   logic [QW-1:0]            q_wdata, q_rdata;

   q2e_front #(
      .INPUT_FRAC_BITS(INPUT_FRAC_BITS), .TERM_W(TERM_W)
   ) u_front (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_qx(req_qx), .req_qy(req_qy), .req_qz(req_qz), .req_qw(req_qw),
      .q_stat(q_stat), .push(push),
      .yaw_y(f_yaw_y), .yaw_x(f_yaw_x), .pit_y(f_pit_y), .pit_x(f_pit_x),
      .sin_q30(f_sin), .cos_q30(f_cos), .clamped(f_clamp)
   );

   assign q_wdata = {f_yaw_y, f_yaw_x, f_pit_y, f_pit_x, f_sin, f_cos, f_clamp};
   assign {b_yaw_y, b_yaw_x, b_pit_y, b_pit_x, b_sin, b_cos, b_clamp} = q_rdata;

   q2e_queue #(
      .W(QW)
   ) u_queue (
      .clock(clock), .reset(reset),
      .push(push), .wdata(q_wdata), .pop(pop), .rdata(q_rdata), .stat(q_stat)
   );

   q2e_back #(
      .TERM_W(TERM_W), .CORDIC_STEPS(CORDIC_STEPS)
   ) u_back (
      .clock(clock), .reset(reset),
      .q_stat(q_stat), .pop(pop),
      .yaw_y(b_yaw_y), .yaw_x(b_yaw_x), .pit_y(b_pit_y), .pit_x(b_pit_x),
      .sin_q30(b_sin), .cos_q30(b_cos), .clamped(b_clamp),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_yaw_angle(rsp_yaw_angle), .rsp_pitch_angle(rsp_pitch_angle),
      .rsp_roll_angle(rsp_roll_angle), .rsp_roll_clamped(rsp_roll_clamped)
   );

endmodule
`default_nettype wire

@@ tb/quaternion_to_euler_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// quaternion_to_euler_tb
// Drives quaternions through the converter with random idling on both sides
// and checks every result against a bit-exact CORDIC angle predictor.
// ----------------------------------------------------------------------------
module quaternion_to_euler_tb;
   import q2e_pkg::*;

   localparam int FRAC       = 14;
   localparam int STEPS      = 16;
   localparam int LATENCY    = 39 + STEPS;
   localparam int NUM_RANDOM = 1200;
   localparam int CYCLE_LIMIT = 400000;
   localparam longint PI_ANGLE = 64'sd3373259426;

   typedef struct packed {
      logic signed [YAW_W-1:0]  yaw;
      logic signed [YAW_W-1:0]  pitch;
      logic signed [ROLL_W-1:0] roll;
      logic                     clamped;
   } angles_type;

   typedef struct {
      logic signed [COMP_W-1:0] qx, qy, qz, qw;
      logic                     known;
      angles_type               angles;
   } quat_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [COMP_W-1:0] req_qx = '0, req_qy = '0, req_qz = '0, req_qw = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [YAW_W-1:0]  rsp_yaw_angle, rsp_pitch_angle;
   logic signed [ROLL_W-1:0] rsp_roll_angle;
   logic rsp_roll_clamped;

   angles_type   expected_angles[$];
   quat_row_type directed_rows[$];
   int           error_count = 0;
   int           cycle_count = 0;
   logic         calm_receiver = 1'b0;

   quaternion_to_euler #(.INPUT_FRAC_BITS(FRAC), .CORDIC_STEPS(STEPS)) u_dut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic longint shift_floor(longint v, int n);
      return v >>> n;
   endfunction

   // Q30 atan2 by vectoring CORDIC, with half-plane fold for negative x
   function automatic longint cordic_atan2(longint y, longint x);
      longint base, acc, xs, ys, m, ax, ay;
      base = 0;
      acc  = 0;
      if (x < 0) begin
         base = (y >= 0) ? PI_ANGLE : -PI_ANGLE;
         x = -x;
         y = -y;
      end
      ax = (x < 0) ? -x : x;
      ay = (y < 0) ? -y : y;
      m = (ax > ay) ? ax : ay;
      if (m == 0) return base;
      while (m >= (64'sd1 <<< 40)) begin
         x = shift_floor(x, 1);
         y = shift_floor(y, 1);
         m = m >>> 1;
      end
      while (m < (64'sd1 <<< 39)) begin
         x = x * 2;
         y = y * 2;
         m = m <<< 1;
      end
      for (int i = 0; i < STEPS; i++) begin
         xs = shift_floor(x, i);
         ys = shift_floor(y, i);
         if (y >= 0) begin
            x = x + ys;
            y = y - xs;
            acc += longint'(atan_q30(i[4:0]));
         end else begin
            x = x - ys;
            y = y + xs;
            acc -= longint'(atan_q30(i[4:0]));
         end
      end
      return base + acc;
   endfunction

   function automatic longint int_sqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return longint'(r);
   endfunction

   function automatic longint round_q12(longint a, longint lim);
      longint r;
      r = shift_floor(a + (64'sd1 <<< 17), 18);
      if (r > lim) r = lim;
      if (r < -lim) r = -lim;
      return r;
   endfunction

   function automatic angles_type euler_angles(logic signed [COMP_W-1:0] qx, qy, qz, qw);
      longint x, y, z, w, unity, s, s30, c30;
      angles_type res;
      x = qx; y = qy; z = qz; w = qw;
      unity = 64'sd1 <<< (2 * FRAC);
      s = 2*x*y + 2*z*w;
      res.clamped = 1'b0;
      if (s > unity) begin s = unity; res.clamped = 1'b1; end
      if (s < -unity) begin s = -unity; res.clamped = 1'b1; end
      s30 = s * (64'sd1 <<< (30 - 2 * FRAC));
      c30 = int_sqrt((64'd1 << 60) - longint'(s30 * s30));
      res.yaw   = YAW_W'(round_q12(cordic_atan2(2*y*w - 2*x*z, unity - 2*y*y - 2*z*z),
                                   YAW_LIM));
      res.pitch = YAW_W'(round_q12(cordic_atan2(2*x*w - 2*y*z, unity - 2*x*x - 2*z*z),
                                   YAW_LIM));
      res.roll  = ROLL_W'(round_q12(cordic_atan2(s30, c30), ROLL_LIM));
      return res;
   endfunction

   task automatic add_row(int x, int y, int z, int w, logic known = 1'b0,
                          int yaw = 0, int pitch = 0, int roll = 0, logic clamped = 1'b0);
      quat_row_type r;
      r.qx = COMP_W'(x); r.qy = COMP_W'(y); r.qz = COMP_W'(z); r.qw = COMP_W'(w);
      r.known = known;
      r.angles.yaw = YAW_W'(yaw); r.angles.pitch = YAW_W'(pitch);
      r.angles.roll = ROLL_W'(roll); r.angles.clamped = clamped;
      directed_rows.push_back(r);
   endtask

   task automatic send_quat(logic signed [COMP_W-1:0] x, y, z, w, logic idle_ok);
      while (idle_ok && $urandom_range(99) < 20) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_qx <= x; req_qy <= y; req_qz <= z; req_qw <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // random component: full range, moderate, extreme or near zero
   function automatic logic signed [COMP_W-1:0] comp_rand();
      case ($urandom_range(3))
         0: return COMP_W'($urandom);
         1: return COMP_W'(int'($urandom_range(32767)) - 16384);
         2: return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
         default: return COMP_W'(int'($urandom_range(16)) - 8);
      endcase
   endfunction

   // receiver: random stall except during a calm stretch
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      rsp_stall <= !calm_receiver && ($urandom_range(99) < 20);
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_angles.size() == 0) begin
            $error("unexpected result: yaw=%0d", rsp_yaw_angle);
            error_count++;
         end else begin
            angles_type e;
            e = expected_angles.pop_front();
            if (rsp_yaw_angle !== e.yaw) begin
               $error("yaw_angle: expected %0d, got %0d", e.yaw, rsp_yaw_angle);
               error_count++;
            end
            if (rsp_pitch_angle !== e.pitch) begin
               $error("pitch_angle: expected %0d, got %0d", e.pitch, rsp_pitch_angle);
               error_count++;
            end
            if (rsp_roll_angle !== e.roll) begin
               $error("roll_angle: expected %0d, got %0d", e.roll, rsp_roll_angle);
               error_count++;
            end
            if (rsp_roll_clamped !== e.clamped) begin
               $error("roll_clamped: expected %0d, got %0d", e.clamped, rsp_roll_clamped);
               error_count++;
            end
         end
      end
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // queue the prediction on each accepted transaction
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall)
         expected_angles.push_back(euler_angles(req_qx, req_qy, req_qz, req_qw));
   end

   initial begin
      logic signed [COMP_W-1:0] x, y, z, w;
      // identity and zero quaternion: all angles zero
      add_row(0, 0, 0, 16384, 1'b1, 0, 0, 0, 1'b0);
      add_row(0, 0, 0, 0, 1'b1, 0, 0, 0, 1'b0);
      // large x,y: asin argument saturates high and low, both cosines negative
      add_row(32767, 32767, 0, 0, 1'b1, YAW_LIM, YAW_LIM, ROLL_LIM, 1'b1);
      add_row(32767, -32768, 0, 0, 1'b1, YAW_LIM, YAW_LIM, -ROLL_LIM, 1'b1);
      add_row(-32768, -32768, -32768, -32768);
      add_row(32767, 32767, 32767, 32767);
      add_row(-32768, 32767, -32768, 32767);
      add_row(16384, 0, 0, 0);
      add_row(0, 16384, 0, 0);
      add_row(0, 0, 16384, 0);
      add_row(11585, 0, 0, 11585);
      add_row(0, 11585, 0, -11585);
      add_row(0, 0, 11585, 11585);
      add_row(8192, 8192, 8192, 8192);
      add_row(8192, -8192, 8192, -8192);
      add_row(0, 0, 23170, 0);
      add_row(23170, 0, 0, 0);
      add_row(1, -1, 1, -1);
      add_row(-1, 0, 0, 0);
      add_row(0, 0, 0, -16384);

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].known) begin
            if (euler_angles(directed_rows[i].qx, directed_rows[i].qy, directed_rows[i].qz,
                             directed_rows[i].qw) != directed_rows[i].angles) begin
               $error("directed row %0d: predictor disagrees with typed-in angles", i);
               error_count++;
            end
         end
         send_quat(directed_rows[i].qx, directed_rows[i].qy, directed_rows[i].qz,
                   directed_rows[i].qw, 1'b1);
      end

      for (int n = 0; n < NUM_RANDOM; n++) begin
         // calm stretch on both sides
         calm_receiver <= (n >= 400 && n < 550);
         // hold off until the pipeline drains once
         if (n == 700) begin
            req_valid <= 1'b0;
            @(posedge clock);
            while (expected_angles.size() != 0) @(posedge clock);
         end
         x = comp_rand(); y = comp_rand(); z = comp_rand(); w = comp_rand();
         send_quat(x, y, z, w, !(n >= 400 && n < 550));
      end
      req_valid <= 1'b0;
      calm_receiver <= 1'b0;

      while (expected_angles.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);

      if (error_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

@@ filelist.f @@
sv/q2e_pkg.sv
sv/q2e_front.sv
sv/q2e_queue.sv
sv/q2e_atan.sv
sv/q2e_back.sv
sv/quaternion_to_euler.sv
tb/quaternion_to_euler_tb.sv
